// ===== rtl/dsh_pkg.sv =====
package dsh_pkg;

    localparam int DEF_MAX_LEVELS  = 7;
    localparam int DEF_HEIGHT_BITS = 16;

    localparam int CFG_W = 17;
    localparam int LVL_W = 3;

    localparam logic [CFG_W-1:0] ONE_Q16      = 17'h10000;
    localparam logic [CFG_W-1:0] ROUGH_RESET  = 17'h08000;
    localparam logic [LVL_W-1:0] LEVELS_RESET = 3'd7;

    localparam logic [1:0] PH_CORNER = 2'd0;
    localparam logic [1:0] PH_CENTRE = 2'd1;
    localparam logic [1:0] PH_EDGE   = 2'd2;

    localparam logic REG_ROUGHNESS = 1'b0;
    localparam logic REG_LEVELS    = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic       done;
        logic [3:0] use_mask;
    } pt_ctrl_t;

endpackage

// ===== rtl/dsh_ram.sv =====
module dsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16641,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dsh_div.sv =====
module dsh_div #(
    parameter int SW = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [SW-1:0] x,
    input  logic [2:0]    cnt,
    output logic [SW-1:0] q,
    output logic          q_valid
);

    localparam logic [SW-1:0] RECIP3 = SW'((64'd1 << SW) / 64'd3);

    logic [SW-1:0]   x_reg;
    logic [2:0]      cnt_reg;
    logic [2*SW-1:0] prod_reg;
    logic            valid_reg;

    logic [SW-1:0] est;
    logic [SW+1:0] rem;
    logic [SW-1:0] third;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x;
            cnt_reg  <= cnt;
            prod_reg <= (2*SW)'(x) * (2*SW)'(RECIP3);
        end
    end

    // reciprocal estimate is exact or one low
    always_comb begin
        est   = prod_reg[2*SW-1:SW];
        rem   = (SW+2)'(x_reg) - (SW+2)'(est) * (SW+2)'(3);
        third = (rem >= (SW+2)'(3)) ? est + SW'(1) : est;
        case (cnt_reg)
            3'd1:    q = x_reg;
            3'd2:    q = x_reg >> 1;
            3'd3:    q = third;
            3'd4:    q = x_reg >> 2;
            default: q = '0;
        endcase
    end

    assign q_valid = valid_reg;

endmodule

// ===== rtl/dsh_walker.sv =====
module dsh_walker #(
    parameter int MAX_LEVELS = dsh_pkg::DEF_MAX_LEVELS,
    localparam int CW = MAX_LEVELS + 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [dsh_pkg::LVL_W-1:0] levels,
    input  logic                     restart,
    input  logic [dsh_pkg::LVL_W-1:0] restart_levels,
    input  logic                     advance,
    output logic [CW-1:0]            pt_row,
    output logic [CW-1:0]            pt_col,
    output logic [CW-1:0]            pt_half,
    output dsh_pkg::pt_ctrl_t        pt_ctrl
);

    localparam int RST_LVL = (int'(dsh_pkg::LEVELS_RESET) > MAX_LEVELS) ?
                             MAX_LEVELS : int'(dsh_pkg::LEVELS_RESET);
    localparam logic [CW-1:0] N_RST = CW'(1) << RST_LVL;

    function automatic logic [CW-1:0] side_of(input logic [dsh_pkg::LVL_W-1:0] lv);
        logic [3:0] l;
        if (4'(lv) > 4'(MAX_LEVELS)) begin
            l = 4'(MAX_LEVELS);
        end else begin
            l = 4'(lv);
        end
        return CW'(1) << l;
    endfunction

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    cidx_reg, cidx_next;

    logic [CW-1:0] n, st, hf, rw, cl, st_half;
    logic [1:0]    ph, ci, ci_inc;
    logic [CW:0]   n_w, col_w, row_st_w, row_hf_w, col_hf_w;
    logic          done;

    always_comb begin
        n  = side_of(levels);
        ph = phase_reg;
        st = step_reg;
        rw = row_reg;
        cl = col_reg;
        ci = cidx_reg;
        // stale or spent state starts the map over
        if (ph > dsh_pkg::PH_EDGE || st < CW'(2)) begin
            ph = dsh_pkg::PH_CORNER;
            ci = 2'd0;
            st = n;
            rw = '0;
            cl = '0;
        end
        hf       = st >> 1;
        st_half  = st >> 1;
        ci_inc   = ci + 2'd1;
        n_w      = {1'b0, n};
        col_w    = {1'b0, cl} + {1'b0, st};
        row_st_w = {1'b0, rw} + {1'b0, st};
        row_hf_w = {1'b0, rw} + {1'b0, hf};
        col_hf_w = {1'b0, cl} + {1'b0, hf};

        phase_next = ph;
        step_next  = st;
        row_next   = rw;
        col_next   = cl;
        cidx_next  = ci;
        done       = 1'b0;
        pt_row     = rw;
        pt_col     = cl;
        pt_ctrl.kind     = ph;
        pt_ctrl.use_mask = 4'b0000;

        unique case (ph)
            dsh_pkg::PH_CORNER: begin
                pt_row    = ci[1] ? n : '0;
                pt_col    = ci[0] ? n : '0;
                cidx_next = ci_inc;
                if (ci_inc == 2'd0) begin
                    if (n < CW'(2)) begin
                        done = 1'b1;
                    end else begin
                        phase_next = dsh_pkg::PH_CENTRE;
                        step_next  = n;
                        row_next   = n >> 1;
                        col_next   = n >> 1;
                    end
                end
            end
            dsh_pkg::PH_CENTRE: begin
                pt_ctrl.use_mask = 4'b1111;
                if (col_w > n_w) begin
                    col_next = hf;
                    if (row_st_w > n_w) begin
                        phase_next = dsh_pkg::PH_EDGE;
                        row_next   = '0;
                        col_next   = hf;
                    end else begin
                        row_next = row_st_w[CW-1:0];
                    end
                end else begin
                    col_next = col_w[CW-1:0];
                end
            end
            dsh_pkg::PH_EDGE: begin
                pt_ctrl.use_mask[0] = (rw >= hf);
                pt_ctrl.use_mask[1] = (row_hf_w <= n_w);
                pt_ctrl.use_mask[2] = (cl >= hf);
                pt_ctrl.use_mask[3] = (col_hf_w <= n_w);
                if (col_w > n_w) begin
                    if (row_hf_w > n_w) begin
                        step_next = st_half;
                        if (st_half > CW'(1)) begin
                            phase_next = dsh_pkg::PH_CENTRE;
                            row_next   = st_half >> 1;
                            col_next   = st_half >> 1;
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        row_next = row_hf_w[CW-1:0];
                        col_next = ((row_hf_w[CW-1:0] & (st - CW'(1))) == '0) ? hf : '0;
                    end
                end else begin
                    col_next = col_w[CW-1:0];
                end
            end
            default: begin
                phase_next = dsh_pkg::PH_CORNER;
            end
        endcase

        if (done) begin
            phase_next = dsh_pkg::PH_CORNER;
            cidx_next  = 2'd0;
            step_next  = n;
            row_next   = '0;
            col_next   = '0;
        end
        pt_half      = hf;
        pt_ctrl.done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dsh_pkg::PH_CORNER;
            cidx_reg  <= 2'd0;
            step_reg  <= N_RST;
            row_reg   <= '0;
            col_reg   <= '0;
        end else if (restart) begin
            phase_reg <= dsh_pkg::PH_CORNER;
            cidx_reg  <= 2'd0;
            step_reg  <= side_of(restart_levels);
            row_reg   <= '0;
            col_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            cidx_reg  <= cidx_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

// ===== rtl/diamond_square_height_map_unit.sv =====
// corner points: the input beat goes straight from idle to the finish state, which registers the result
// centre and edge points: the beat goes through the read, last, divide-wait, multiply and finish states,
// with four neighbor reads through the single read port plus divide and blend stages
// a waiting result does not block the next input beat until its point is finished
// reset (aresetn low, synchronous) clears control, roughness 1/2, levels 7, corner phase;
// the height store is not cleared, each point is read only after it was written in this map
module diamond_square_height_map_unit #(
    parameter int MAX_LEVELS  = dsh_pkg::DEF_MAX_LEVELS,
    parameter int HEIGHT_BITS = dsh_pkg::DEF_HEIGHT_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [dsh_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,  // random_sample
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,  // point_row, point_col, height
    output logic                      m_tlast   // last_point
);

    localparam int CW     = MAX_LEVELS + 1;
    localparam int HB     = HEIGHT_BITS;
    localparam int SW     = HB + 2;
    localparam int STRIDE = (1 << MAX_LEVELS) + 1;
    localparam int DEPTH  = STRIDE * STRIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int AFW    = 2 * MAX_LEVELS + 2;
    localparam int PW     = HB + 19;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] rr, input logic [CW-1:0] cc);
        logic [AFW-1:0] full;
        full = (AFW'(rr) << MAX_LEVELS) + AFW'(rr) + AFW'(cc);
        return full[AW-1:0];
    endfunction

    logic [dsh_pkg::CFG_W-1:0] rough_reg;
    logic [dsh_pkg::LVL_W-1:0] levels_reg;
    logic                      lvl_restart;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        nb_idx_reg, nb_idx_next;
    logic              use_pend_reg, use_pend_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [HB-1:0]     sample_reg;
    logic [HB-1:0]     avg_reg;
    logic signed [PW-1:0] prod_reg;
    logic [CW-1:0]     prow_reg, pcol_reg, phalf_reg;
    dsh_pkg::pt_ctrl_t ctrl_reg;

    logic [CW-1:0]     wk_row, wk_col, wk_half;
    dsh_pkg::pt_ctrl_t wk_ctrl;

    logic              in_fire, fin_fire;
    logic [HB+15:0]    sample_w;
    logic [HB-1:0]     sample_in;
    logic [HB-1:0]     rd_data;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     nb_row, nb_col;
    logic [SW-1:0]     rd_term;
    logic [SW-1:0]     dv_x;
    logic [2:0]        dv_cnt;
    logic              dv_start;
    logic [SW-1:0]     dv_q;
    logic              dv_q_valid;
    logic [dsh_pkg::CFG_W-1:0] rough_eff;
    logic signed [HB:0]   diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] blend_w;
    logic [HB-1:0]     h_final;
    logic [HB+15:0]    h_w;
    logic [CW+7:0]     row_w, col_w;

    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic              m_tlast_reg;

    // configuration
    assign lvl_restart = cfg_we && (cfg_index == dsh_pkg::REG_LEVELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rough_reg  <= dsh_pkg::ROUGH_RESET;
            levels_reg <= dsh_pkg::LEVELS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dsh_pkg::REG_ROUGHNESS: rough_reg  <= cfg_wdata;
                dsh_pkg::REG_LEVELS:    levels_reg <= cfg_wdata[dsh_pkg::LVL_W-1:0];
                default:                rough_reg  <= rough_reg;
            endcase
        end
    end

    dsh_walker #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_walker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .levels         (levels_reg),
        .restart        (lvl_restart),
        .restart_levels (cfg_wdata[dsh_pkg::LVL_W-1:0]),
        .advance        (in_fire),
        .pt_row         (wk_row),
        .pt_col         (wk_col),
        .pt_half        (wk_half),
        .pt_ctrl        (wk_ctrl)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign fin_fire  = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);
    assign sample_w  = {s_tdata, {HB{1'b0}}};
    assign sample_in = sample_w[HB+15:16];

    // neighbor coordinates: diagonal for centre points, axial for edge points
    always_comb begin
        nb_row = prow_reg;
        nb_col = pcol_reg;
        case (nb_idx_reg)
            2'd0: begin
                nb_row = prow_reg - phalf_reg;
                nb_col = (ctrl_reg.kind == dsh_pkg::PH_CENTRE) ? pcol_reg - phalf_reg : pcol_reg;
            end
            2'd1: begin
                if (ctrl_reg.kind == dsh_pkg::PH_CENTRE) begin
                    nb_row = prow_reg - phalf_reg;
                    nb_col = pcol_reg + phalf_reg;
                end else begin
                    nb_row = prow_reg + phalf_reg;
                end
            end
            2'd2: begin
                nb_col = pcol_reg - phalf_reg;
                if (ctrl_reg.kind == dsh_pkg::PH_CENTRE) begin
                    nb_row = prow_reg + phalf_reg;
                end
            end
            default: begin
                nb_col = pcol_reg + phalf_reg;
                if (ctrl_reg.kind == dsh_pkg::PH_CENTRE) begin
                    nb_row = prow_reg + phalf_reg;
                end
            end
        endcase
        rd_addr = ctrl_reg.use_mask[nb_idx_reg] ? addr_of(nb_row, nb_col) : '0;
    end

    dsh_ram #(
        .WIDTH (HB),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (fin_fire),
        .wr_addr (addr_of(prow_reg, pcol_reg)),
        .wr_data (h_final),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_term  = use_pend_reg ? SW'(rd_data) : '0;
    assign dv_x     = sum_reg + rd_term;
    assign dv_cnt   = (ctrl_reg.kind == dsh_pkg::PH_CENTRE) ? 3'd4 :
                      3'($countones(ctrl_reg.use_mask));
    assign dv_start = (state_reg == S_LAST);

    dsh_div #(
        .SW(SW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .x       (dv_x),
        .cnt     (dv_cnt),
        .q       (dv_q),
        .q_valid (dv_q_valid)
    );

    // blend: avg + r * (sample - avg) / 2^16, floor
    always_comb begin
        rough_eff = (rough_reg > dsh_pkg::ONE_Q16) ? dsh_pkg::ONE_Q16 : rough_reg;
        diff      = $signed({1'b0, sample_reg}) - $signed({1'b0, avg_reg});
        prod_next = $signed({1'b0, rough_eff}) * diff;
        blend_w   = $signed(PW'(avg_reg)) + (prod_reg >>> 16);
        h_final   = (ctrl_reg.kind == dsh_pkg::PH_CORNER) ? sample_reg : blend_w[HB-1:0];
        h_w       = {h_final, 16'h0000};
        row_w     = {8'h00, prow_reg};
        col_w     = {8'h00, pcol_reg};
    end

    always_comb begin
        state_next    = state_reg;
        nb_idx_next   = nb_idx_reg;
        use_pend_next = use_pend_reg;
        sum_next      = sum_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    nb_idx_next   = 2'd0;
                    use_pend_next = 1'b0;
                    sum_next      = '0;
                    state_next    = (wk_ctrl.kind == dsh_pkg::PH_CORNER) ? S_FIN : S_READ;
                end
            end
            S_READ: begin
                use_pend_next = ctrl_reg.use_mask[nb_idx_reg];
                sum_next      = sum_reg + rd_term;
                nb_idx_next   = nb_idx_reg + 2'd1;
                if (nb_idx_reg == 2'd3) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: state_next = S_DIVW;
            S_DIVW: begin
                if (dv_q_valid) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_FIN;
            S_FIN: begin
                if (fin_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nb_idx_reg   <= 2'd0;
            use_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nb_idx_reg   <= nb_idx_next;
            use_pend_reg <= use_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (in_fire) begin
            sample_reg <= sample_in;
            prow_reg   <= wk_row;
            pcol_reg   <= wk_col;
            phalf_reg  <= wk_half;
            ctrl_reg   <= wk_ctrl;
        end
        if (state_reg == S_DIVW) begin
            avg_reg <= dv_q[HB-1:0];
        end
        if (state_reg == S_MUL) begin
            prod_reg <= prod_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_tdata_reg <= {h_w[HB+15:HB], col_w[7:0], row_w[7:0]};
            m_tlast_reg <= ctrl_reg.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_corner_skips_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && wk_ctrl.kind == dsh_pkg::PH_CORNER |=> state_reg == S_FIN)
        else $error("corner point did not go straight to finish");

    a_rest_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && wk_ctrl.kind != dsh_pkg::PH_CORNER |=> state_reg == S_READ)
        else $error("centre or edge point skipped neighbor reads");

    a_div_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_q_valid |-> state_reg == S_DIVW)
        else $error("divider result outside its wait state");

    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_FIN)
        else $error("output beat raised without a finished point");

    a_centre_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_READ && ctrl_reg.kind == dsh_pkg::PH_CENTRE |->
        ctrl_reg.use_mask == 4'b1111)
        else $error("centre point missing a diagonal neighbor");

endmodule
